>>> rtl/tip_pkg.sv
// shared types, constants and the digit decoder of the text to integer parser
package tip_pkg;

  localparam int unsigned MaxStringDef = 4095;
  localparam int unsigned EndW         = 12;
  localparam int unsigned AccW         = 31;
  localparam int unsigned BaseW        = 6;
  localparam int unsigned ProdW        = AccW + BaseW + 1;

  localparam logic [BaseW-1:0] RadixReset = 6'd10;
  localparam logic [BaseW-1:0] BaseOct    = 6'd8;
  localparam logic [BaseW-1:0] BaseDec    = 6'd10;
  localparam logic [BaseW-1:0] BaseHex    = 6'd16;
  localparam logic [BaseW-1:0] BaseDetect = 6'd0;

  // register indexes on the configuration port
  localparam logic RegRadix = 1'b0;

  localparam logic [7:0] NotDigit = 8'hff;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChLowZ   = 8'h7a;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpX    = 8'h58;
  localparam logic [7:0] ChUpZ    = 8'h5a;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_WS     = 6'b000010,
    PH_PREFIX = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_AFTERX = 6'b010000,
    PH_DIGITS = 6'b100000
  } tip_phase_e;

  typedef struct packed {
    tip_phase_e            phase;
    logic                  negative;
    logic [BaseW-1:0]      base;
    logic [AccW-1:0]       acc;
    logic                  overflowed;
    logic                  got_digit;
  } tip_state_t;

  typedef struct packed {
    logic signed [31:0]    value;
    logic [EndW-1:0]       end_offset;
    logic                  no_digits;
    logic                  saturated;
  } tip_result_t;

  // digit value of an alphanumeric character, NotDigit otherwise
  function automatic logic [7:0] tip_digit(input logic [7:0] c);
    logic [7:0] d;
    d = NotDigit;
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
    end else if (c >= ChLowA && c <= ChLowZ) begin
      d = c - ChLowA + 8'd10;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = c - ChUpA + 8'd10;
    end
    return d;
  endfunction

endpackage

>>> rtl/tip_cfg.sv
// configuration register bank with its apb-style port
module tip_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [tip_pkg::BaseW-1:0] radix_o
);
  import tip_pkg::*;

  logic [BaseW-1:0] radix_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegRadix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (wr_en) begin
      radix_q <= pwdata[BaseW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegRadix) begin
      prdata = 32'(radix_q);
    end
  end

  assign radix_o = radix_q;

endmodule

>>> rtl/tip_step.sv
// next-state and result logic for one character
module tip_step #(
  parameter int unsigned MaxString = tip_pkg::MaxStringDef,
  parameter int unsigned PosW      = $clog2(MaxString + 1)
) (
  input  logic [7:0]                ch_i,
  input  logic                      first_i,
  input  logic [tip_pkg::BaseW-1:0] radix_i,
  input  tip_pkg::tip_state_t       st_i,
  input  logic [PosW-1:0]           pos_i,
  output tip_pkg::tip_state_t       st_o,
  output logic [PosW-1:0]           pos_o,
  output logic                      res_valid_o,
  output tip_pkg::tip_result_t      res_o
);
  import tip_pkg::*;

  localparam int unsigned ExtW = (PosW > EndW) ? PosW : EndW;
  localparam logic [ExtW-1:0] EndMax  = ExtW'((1 << EndW) - 1);
  localparam logic [PosW-1:0] PosLast = PosW'(MaxString);

  tip_state_t       w;
  tip_state_t       nxt;
  logic [PosW-1:0]  wpos;
  logic [7:0]       d;
  logic [BaseW-1:0] base_dig;
  logic             do_prefix;
  logic             do_digit;
  logic             do_finish;
  logic             do_hexend;
  logic             adv;
  logic             is_ws;
  logic [ProdW-1:0] prod;
  logic [ExtW-1:0]  end_ext;
  logic [PosW-1:0]  end_pos;

  always_comb begin
    w = st_i;
    wpos = pos_i;
    if (first_i) begin
      w.phase      = PH_WS;
      w.negative   = 1'b0;
      w.base       = radix_i;
      w.acc        = '0;
      w.overflowed = 1'b0;
      w.got_digit  = 1'b0;
      wpos         = '0;
    end

    nxt       = w;
    d         = tip_digit(ch_i);
    is_ws     = (ch_i == ChSpace) || (ch_i >= ChTab && ch_i <= ChCr);
    base_dig  = w.base;
    do_prefix = 1'b0;
    do_digit  = 1'b0;
    do_finish = 1'b0;
    do_hexend = 1'b0;
    adv       = 1'b0;
    prod      = '0;

    case (w.phase)
      PH_WS: begin
        if (is_ws) begin
          adv = 1'b1;
        end else if (ch_i == ChPlus || ch_i == ChMinus) begin
          nxt.negative = (ch_i == ChMinus);
          nxt.phase    = PH_PREFIX;
          adv          = 1'b1;
        end else begin
          do_prefix = 1'b1;
        end
      end
      PH_PREFIX: begin
        do_prefix = 1'b1;
      end
      PH_ZERO: begin
        if (ch_i == ChLowX || ch_i == ChUpX) begin
          nxt.base  = BaseHex;
          nxt.phase = PH_AFTERX;
          adv       = 1'b1;
        end else begin
          nxt.phase = PH_DIGITS;
          do_digit  = 1'b1;
        end
      end
      PH_AFTERX: begin
        if (d < 8'(BaseHex)) begin
          nxt.phase = PH_DIGITS;
          do_digit  = 1'b1;
        end else begin
          do_hexend = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
        nxt.phase = PH_IDLE;
      end
    endcase

    // leading zero picks octal in detect mode, or opens a hex prefix
    if (do_prefix) begin
      if (w.base == BaseDetect && ch_i == ChZero) begin
        nxt.base      = BaseOct;
        nxt.got_digit = 1'b1;
        nxt.phase     = PH_ZERO;
        adv           = 1'b1;
      end else if (w.base == BaseHex && ch_i == ChZero) begin
        nxt.got_digit = 1'b1;
        nxt.phase     = PH_ZERO;
        adv           = 1'b1;
      end else begin
        base_dig  = (w.base == BaseDetect) ? BaseDec : w.base;
        nxt.base  = base_dig;
        nxt.phase = PH_DIGITS;
        do_digit  = 1'b1;
      end
    end

    if (do_digit) begin
      if (d >= 8'(base_dig)) begin
        do_finish = 1'b1;
      end else begin
        prod = ProdW'(w.acc) * ProdW'(base_dig) + ProdW'(d);
        if (prod > ProdW'(32'h7fff_ffff)) begin
          nxt.overflowed = 1'b1;
        end else begin
          nxt.acc = prod[AccW-1:0];
        end
        nxt.got_digit = 1'b1;
        adv           = 1'b1;
      end
    end

    pos_o = wpos;
    if (adv && wpos < PosLast) begin
      pos_o = wpos + PosW'(1);
    end

    // end offset, clamped to the output field
    end_pos = do_hexend ? (wpos - PosW'(1)) : wpos;
    end_ext = ExtW'(end_pos);

    res_valid_o = do_finish || do_hexend;
    res_o       = '0;
    if (do_finish && w.got_digit) begin
      if (w.overflowed) begin
        res_o.value = w.negative ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        res_o.value = w.negative ? (32'sd0 - $signed({1'b0, w.acc}))
                                 : $signed({1'b0, w.acc});
      end
      res_o.saturated = w.overflowed;
    end
    if ((do_finish && w.got_digit) || do_hexend) begin
      res_o.end_offset = (end_ext > EndMax) ? EndMax[EndW-1:0] : end_ext[EndW-1:0];
    end
    res_o.no_digits = do_finish && !w.got_digit;
    if (res_valid_o) begin
      nxt.phase = PH_IDLE;
    end

    st_o = nxt;
  end

endmodule

>>> rtl/text_to_integer_parser_core.sv
// top level: input register, parser state, result register and config port
// path: a closing character is taken into the input register, and its result
// goes from the step logic into the result register, which m_axis back-pressure can hold
// throughput: one character per cycle unless m_axis stalls (one multiply-add step)
// reset: radix 10, no string open, input and result registers empty
module text_to_integer_parser_core #(
  parameter int unsigned MaxString = tip_pkg::MaxStringDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch[7:0]
  input  logic        s_axis_tuser,   // first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // value[31:0], end_offset[43:32], zeros[47:44]
  output logic [1:0]  m_axis_tuser,   // no_digits[0], saturated[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tip_pkg::*;

  localparam int unsigned PosW = $clog2(MaxString + 1);

  logic [BaseW-1:0] radix;
  logic             in_valid_q;
  logic [7:0]       in_ch_q;
  logic             in_first_q;
  tip_state_t       st_q;
  tip_state_t       st_d;
  logic [PosW-1:0]  pos_q;
  logic [PosW-1:0]  pos_d;
  logic             res_valid;
  tip_result_t      res;
  logic             out_valid_q;
  tip_result_t      out_res_q;
  logic             stage_go;

  tip_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix_o (radix)
  );

  tip_step #(
    .MaxString (MaxString),
    .PosW      (PosW)
  ) u_step (
    .ch_i        (in_ch_q),
    .first_i     (in_first_q),
    .radix_i     (radix),
    .st_i        (st_q),
    .pos_i       (pos_q),
    .st_o        (st_d),
    .pos_o       (pos_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // the step may run whenever the result register is free or being drained
  assign stage_go      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || stage_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q    <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_IDLE;
      st_q.negative   <= 1'b0;
      st_q.base       <= '0;
      st_q.acc        <= '0;
      st_q.overflowed <= 1'b0;
      st_q.got_digit  <= 1'b0;
      pos_q           <= '0;
      out_valid_q     <= 1'b0;
    end else if (stage_go) begin
      out_valid_q <= in_valid_q && res_valid;
      if (in_valid_q) begin
        st_q  <= st_d;
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_go && in_valid_q && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_res_q.end_offset, out_res_q.value};
  assign m_axis_tuser  = {out_res_q.saturated, out_res_q.no_digits};

endmodule
